// ===== hw/rtl/sps_pkg.sv =====
package sps_pkg;

	localparam int unsigned CAPACITY_DEF = 64;
	localparam int unsigned FUNC_W = 2;
	localparam int unsigned POS_W = 32;
	localparam int unsigned FREQ_W = 32;
	localparam int unsigned COUNT_OUT_W = 7;

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [FREQ_W-1:0] freq_t;
	typedef logic [COUNT_OUT_W-1:0] count_out_t;

	localparam func_t FUNC_ADD = 2'd0;
	localparam func_t FUNC_REMOVE = 2'd1;
	localparam func_t FUNC_RANGE = 2'd2;

endpackage

// ===== hw/rtl/sorted_position_set.sv =====
// Channel   Handshake      Ports
// command   start / busy   func, position_first, position_last, frequency_increment
// result    done strobe    status, removed_count, entries_held, frequency_total_out
//
// A word is taken at a clock edge where start is high and busy is low.
// Every operation makes one linear pass over the held entries through a single
// memory read port; an add stops early when it meets its position, or a larger one in a full set.
// An unused func code is answered in the cycle after it is taken.
// The result stands for one cycle under done; the receiver cannot stall it.
// Reset empties the set and clears the total; the memory itself is not cleared.
module sorted_position_set #(
	parameter int unsigned CAPACITY = sps_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  sps_pkg::func_t      func,
	input  sps_pkg::pos_t       position_first,
	input  sps_pkg::pos_t       position_last,
	input  sps_pkg::freq_t      frequency_increment,
	output logic                done,
	output logic                status,
	output sps_pkg::count_out_t removed_count,
	output sps_pkg::count_out_t entries_held,
	output sps_pkg::freq_t      frequency_total_out
);
	import sps_pkg::*;

	localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ADD = 2'd1;
	localparam logic [1:0] S_CMP = 2'd2;

	logic [1:0] state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ra_q;
	logic [CW-1:0] w_q;
	logic ins_q;
	freq_t total_q;

	pos_t first_q;
	pos_t last_q;
	pos_t carry_q;

	pos_t mem [CAPACITY];
	pos_t rd_s1;
	logic rv_s1;
	logic [IW-1:0] ri_s1;

	logic done_q;
	logic status_q;
	logic [CW-1:0] removed_q;
	logic [CW-1:0] held_q;
	freq_t tot_out_q;

	logic re_c;
	logic we_c;
	logic [IW-1:0] wa_c;
	pos_t wd_c;
	logic gt_c;
	logic eq_c;
	logic le_last_c;
	logic keep_c;
	logic end_c;
	logic full_c;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign removed_count = COUNT_OUT_W'(removed_q);
	assign entries_held = COUNT_OUT_W'(held_q);
	assign frequency_total_out = tot_out_q;

	always_comb begin
		gt_c = (rd_s1 > first_q);
		eq_c = (rd_s1 == first_q);
		le_last_c = (rd_s1 <= last_q);
		keep_c = !((gt_c || eq_c) && le_last_c);
		full_c = (count_q == CAP_C);
		end_c = !rv_s1 && (ra_q == count_q);
		re_c = (state_q != S_IDLE) && (ra_q < count_q);
		we_c = 1'b0;
		wa_c = ri_s1;
		wd_c = carry_q;
		unique case (state_q)
			S_ADD: begin
				if (rv_s1) begin
					if (ins_q) begin
						we_c = 1'b1;
					end else if (gt_c && !full_c) begin
						we_c = 1'b1;
						wd_c = first_q;
					end
				end else if (end_c && (ins_q || !full_c)) begin
					we_c = 1'b1;
					wa_c = count_q[IW-1:0];
					wd_c = ins_q ? carry_q : first_q;
				end
			end
			S_CMP: begin
				if (rv_s1 && keep_c) begin
					we_c = 1'b1;
					wa_c = w_q[IW-1:0];
					wd_c = rd_s1;
				end
			end
			default: begin
				we_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[wa_c] <= wd_c;
		end
		if (re_c) begin
			rd_s1 <= mem[ra_q[IW-1:0]];
			ri_s1 <= ra_q[IW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			first_q <= position_first;
			last_q <= (func == FUNC_REMOVE) ? position_first : position_last;
		end
		if (state_q == S_ADD && rv_s1) begin
			carry_q <= rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ra_q <= '0;
			w_q <= '0;
			ins_q <= 1'b0;
			total_q <= '0;
			rv_s1 <= 1'b0;
			done_q <= 1'b0;
			status_q <= 1'b0;
			removed_q <= '0;
			held_q <= '0;
			tot_out_q <= '0;
		end else begin
			done_q <= 1'b0;
			rv_s1 <= re_c;
			if (re_c) begin
				ra_q <= ra_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					ra_q <= '0;
					w_q <= '0;
					ins_q <= 1'b0;
					if (start) begin
						if (func == FUNC_ADD) begin
							total_q <= total_q + frequency_increment;
							state_q <= S_ADD;
						end else if (func == FUNC_REMOVE || func == FUNC_RANGE) begin
							state_q <= S_CMP;
						end else begin
							done_q <= 1'b1;
							status_q <= 1'b0;
							removed_q <= '0;
							held_q <= count_q;
							tot_out_q <= total_q;
						end
					end
				end
				S_ADD: begin
					if (rv_s1) begin
						if (!ins_q && (eq_c || (gt_c && full_c))) begin
							state_q <= S_IDLE;
							done_q <= 1'b1;
							status_q <= !eq_c;
							removed_q <= '0;
							held_q <= count_q;
							tot_out_q <= total_q;
						end else if (!ins_q && gt_c) begin
							ins_q <= 1'b1;
						end
					end else if (end_c) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
						removed_q <= '0;
						tot_out_q <= total_q;
						if (ins_q || !full_c) begin
							count_q <= count_q + 1'b1;
							held_q <= count_q + 1'b1;
							status_q <= 1'b0;
						end else begin
							held_q <= count_q;
							status_q <= 1'b1;
						end
					end
				end
				S_CMP: begin
					if (rv_s1) begin
						if (keep_c) begin
							w_q <= w_q + 1'b1;
						end
					end else if (end_c) begin
						state_q <= S_IDLE;
						count_q <= w_q;
						done_q <= 1'b1;
						status_q <= 1'b0;
						removed_q <= count_q - w_q;
						held_q <= w_q;
						tot_out_q <= total_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
